@@ hdl/utf8d_pkg.sv @@
// Shared types, constants and the byte classifier of the UTF-8 stream decoder.
package utf8d_pkg;

  localparam int unsigned TOK_DEPTH_DEF = 4;
  localparam int unsigned RES_DEPTH_DEF = 4;

  // One input word as it arrives on the push side.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_word_t;

  // One result word as it leaves on the pop side.
  typedef struct packed {
    logic [20:0] code_point;
    logic        code_point_ready;
    logic        buffer_done;
    logic        buffer_valid;
  } out_word_t;

  // Byte classes as seen by the decoder.
  typedef enum logic [2:0] {
    CLS_ASCII,
    CLS_CONT,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_BAD
  } byte_class_t;

  // A classified byte, handed from the front to the back.
  typedef struct packed {
    byte_class_t kind;
    logic [6:0]  payload;
    logic        eob;
  } token_t;

  function automatic byte_class_t classify(input logic [7:0] b);
    byte_class_t k;
    if (b < 8'h80) begin
      k = CLS_ASCII;
    end else if (b < 8'hC0) begin
      k = CLS_CONT;
    end else if (b < 8'hE0) begin
      k = CLS_LEAD2;
    end else if (b < 8'hF0) begin
      k = CLS_LEAD3;
    end else if (b < 8'hF8) begin
      k = CLS_LEAD4;
    end else begin
      k = CLS_BAD;
    end
    return k;
  endfunction

  function automatic logic [6:0] payload_bits(input logic [7:0] b, input byte_class_t k);
    logic [7:0] p;
    unique case (k)
      CLS_ASCII: p = b & 8'h7F;
      CLS_CONT:  p = b & 8'h3F;
      CLS_LEAD2: p = b & 8'h1F;
      CLS_LEAD3: p = b & 8'h0F;
      CLS_LEAD4: p = b & 8'h07;
      default:   p = 8'h00;
    endcase
    return p[6:0];
  endfunction

endpackage

@@ hdl/utf8_stream_decoder.sv @@
// Top level of the UTF-8 stream decoder and validator.
//
// The decoder takes one byte per word on the push side, each marked when it
// ends a buffer, and delivers code points and buffer verdicts on the pop side.
// It accepts one byte per clock cycle while full is low: a pushed byte is
// classified and registered in the byte queue by the front end, and the back
// end retires one queued byte every cycle in which its result queue has room,
// writing any result word it yields into the result queue, from which it can
// then be popped. Both sides behave as queues: full rises only when the byte
// queue holds TOK_DEPTH bytes, and empty stays low while results wait.
// A result word is produced when a sequence completes (code_point_ready set)
// and at each buffer end (buffer_done set, with buffer_valid giving the
// verdict); both flags may be set in one word. Any error (stray continuation
// byte, lead byte of 0xF8 or above, missing continuation, or a buffer that
// ends inside a sequence) is sticky: further bytes are swallowed until the
// buffer ends, and that last byte yields buffer_valid low. Overlong forms and
// surrogate code points are not rejected. All decoding state clears at each
// buffer end. code_point reads zero in words that carry no code point.
module utf8_stream_decoder
  import utf8d_pkg::*;
#(
  parameter int unsigned TOK_DEPTH = TOK_DEPTH_DEF,
  parameter int unsigned RES_DEPTH = RES_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  in_word_t  item,
  output logic      full,
  output out_word_t result,
  output logic      empty,
  input  logic      pop
);

  // Classified bytes waiting for the back end.
  token_t tok;
  logic   tok_empty;
  logic   tok_pop;

  utf8d_front #(
    .TOK_DEPTH(TOK_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item     (item),
    .full     (full),
    .tok_pop  (tok_pop),
    .tok      (tok),
    .tok_empty(tok_empty)
  );

  // The back end holds the sequence state and the result queue.
  utf8d_back #(
    .RES_DEPTH(RES_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .tok      (tok),
    .tok_empty(tok_empty),
    .tok_pop  (tok_pop),
    .result   (result),
    .empty    (empty),
    .pop      (pop)
  );

endmodule

@@ hdl/utf8d_fifo.sv @@
// Small first-in first-out queue of register entries with full and empty flags.
module utf8d_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

@@ hdl/utf8d_front.sv @@
// Front end: classifies each incoming byte and queues the resulting token.
module utf8d_front
  import utf8d_pkg::*;
#(
  parameter int unsigned TOK_DEPTH = TOK_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  in_word_t item,
  output logic     full,
  input  logic     tok_pop,
  output token_t   tok,
  output logic     tok_empty
);

  token_t                 tok_in;
  logic [$bits(token_t)-1:0] tok_raw;

  always_comb begin
    tok_in.kind    = classify(item.data_byte);
    tok_in.payload = payload_bits(item.data_byte, tok_in.kind);
    tok_in.eob     = item.end_of_buffer;
  end

  utf8d_fifo #(
    .WIDTH($bits(token_t)),
    .DEPTH(TOK_DEPTH)
  ) u_tok_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .wdata(tok_in),
    .full (full),
    .pop  (tok_pop),
    .rdata(tok_raw),
    .empty(tok_empty)
  );

  assign tok = token_t'(tok_raw);

endmodule

@@ hdl/utf8d_back.sv @@
// Back end: sequence state, error tracking and the queue of finished results.
module utf8d_back
  import utf8d_pkg::*;
#(
  parameter int unsigned RES_DEPTH = RES_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  token_t    tok,
  input  logic      tok_empty,
  output logic      tok_pop,
  output out_word_t result,
  output logic      empty,
  input  logic      pop
);

  logic [1:0]  bytes_pending;
  logic [1:0]  bytes_pending_next;
  logic [20:0] partial_value;
  logic [20:0] partial_value_next;
  logic        error_seen;
  logic        error_seen_next;

  logic        res_full;
  logic        emit;
  logic        ready;
  logic [20:0] cp;
  logic [20:0] shifted;
  logic [1:0]  pend_dec;
  out_word_t   res_in;
  logic [$bits(out_word_t)-1:0] res_raw;

  // A token is taken whenever one waits and the result queue has room.
  assign tok_pop  = !tok_empty && !res_full;
  assign shifted  = {partial_value[14:0], tok.payload[5:0]};
  assign pend_dec = bytes_pending - 2'd1;

  always_comb begin
    bytes_pending_next = bytes_pending;
    partial_value_next = partial_value;
    error_seen_next    = error_seen;
    ready              = 1'b0;
    cp                 = '0;
    if (!error_seen) begin
      if (bytes_pending != 2'd0) begin
        if (tok.kind == CLS_CONT) begin
          bytes_pending_next = pend_dec;
          partial_value_next = shifted;
          if (pend_dec == 2'd0) begin
            ready              = 1'b1;
            cp                 = shifted;
            partial_value_next = '0;
          end
        end else begin
          error_seen_next = 1'b1;
        end
      end else begin
        unique case (tok.kind)
          CLS_ASCII: begin
            ready = 1'b1;
            cp    = {14'd0, tok.payload};
          end
          CLS_LEAD2: begin
            partial_value_next = {14'd0, tok.payload};
            bytes_pending_next = 2'd1;
          end
          CLS_LEAD3: begin
            partial_value_next = {14'd0, tok.payload};
            bytes_pending_next = 2'd2;
          end
          CLS_LEAD4: begin
            partial_value_next = {14'd0, tok.payload};
            bytes_pending_next = 2'd3;
          end
          default: begin
            error_seen_next = 1'b1;
          end
        endcase
      end
    end

    res_in.code_point       = cp;
    res_in.code_point_ready = ready;
    res_in.buffer_done      = tok.eob;
    res_in.buffer_valid     = tok.eob && !error_seen_next && (bytes_pending_next == 2'd0);
    emit                    = tok_pop && (ready || tok.eob);

    if (tok.eob) begin
      bytes_pending_next = '0;
      partial_value_next = '0;
      error_seen_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= '0;
      partial_value <= '0;
      error_seen    <= 1'b0;
    end else if (tok_pop) begin
      bytes_pending <= bytes_pending_next;
      partial_value <= partial_value_next;
      error_seen    <= error_seen_next;
    end
  end

  utf8d_fifo #(
    .WIDTH($bits(out_word_t)),
    .DEPTH(RES_DEPTH)
  ) u_res_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (emit),
    .wdata(res_in),
    .full (res_full),
    .pop  (pop),
    .rdata(res_raw),
    .empty(empty)
  );

  assign result = out_word_t'(res_raw);

endmodule
